// ----- src/yuvrgb_pkg.sv -----
package yuvrgb_pkg;

  // Widths of the arithmetic path.
  localparam int unsigned PixW   = 8;
  localparam int unsigned ChromW = PixW + 1;            // centered chroma, signed
  localparam int unsigned CoefW  = 18;                  // signed coefficient width
  localparam int unsigned ProdW  = ChromW + CoefW;      // full product width
  localparam int unsigned TermW  = 25;                  // chroma term, signed
  localparam int unsigned SumW   = TermW + 1;           // luma plus chroma term
  localparam int unsigned OutW   = 24;

  // Q16 conversion coefficients.
  localparam logic signed [CoefW-1:0] CoefRv = 18'sd91881;
  localparam logic signed [CoefW-1:0] CoefGu = -18'sd22553;
  localparam logic signed [CoefW-1:0] CoefGv = -18'sd46801;
  localparam logic signed [CoefW-1:0] CoefBu = 18'sd116129;

  localparam logic [PixW-1:0] ChromaOffset = 8'd128;

  // Register map.
  localparam logic RegPixelFormat = 1'b0;

  // Output format codes.
  localparam logic FmtRgb888 = 1'b0;
  localparam logic FmtRgb565 = 1'b1;

  // Clamp a Q16 channel value to 0..255.
  function automatic logic [PixW-1:0] sat_chan(input logic signed [SumW-1:0] x);
    logic [PixW-1:0] res;
    if (x[SumW-1]) begin
      res = '0;
    end else if (x[SumW-2]) begin
      res = '1;
    end else begin
      res = x[23:16];
    end
    return res;
  endfunction

  // Pack one pixel in the selected output format.
  function automatic logic [OutW-1:0] pack_pixel(input logic fmt,
                                                 input logic [PixW-1:0] r,
                                                 input logic [PixW-1:0] g,
                                                 input logic [PixW-1:0] b);
    logic [OutW-1:0] res;
    if (fmt == FmtRgb565) begin
      res = {8'd0, b[7:3], g[7:2], r[7:3]};
    end else begin
      res = {b, g, r};
    end
    return res;
  endfunction

endpackage

// ----- src/yuv420_block_to_rgb_top.sv -----
// Converts one 2x2 block of 4:2:0 video (four luma samples and a shared Cb/Cr
// pair) into four RGB pixels, packed as RGB888 or RGB565 by the pixel_format
// register at byte address 0. The block is a four-stage pipeline: a new block
// is taken on every clock (busy stays low) and its result appears on the
// pixel ports with done_o high once it has passed through all stages after the start
// transaction, for a single cycle. The receiver cannot stall the block and
// must take each result in the cycle it is shown. Change pixel_format only
// while no conversion is in flight.
module yuv420_block_to_rgb_top
  import yuvrgb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input block
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  luma_tl_i,
  input  logic [7:0]  luma_tr_i,
  input  logic [7:0]  luma_bl_i,
  input  logic [7:0]  luma_br_i,
  input  logic [7:0]  chroma_b_i,
  input  logic [7:0]  chroma_r_i,
  // Result
  output logic        done_o,
  output logic [23:0] pixel_tl_o,
  output logic [23:0] pixel_tr_o,
  output logic [23:0] pixel_bl_o,
  output logic [23:0] pixel_br_o
);

  logic fmt_q;

  // Configuration register; only the format bit is kept.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FmtRgb888;
    end else if (psel && penable && pwrite && (paddr[2] == RegPixelFormat)) begin
      fmt_q <= pwdata[0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegPixelFormat) ? {31'd0, fmt_q} : 32'd0;

  // The pipeline never stalls.
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // Stage 1: center chroma and form the four chroma products.
  logic signed [ChromW-1:0] cb_c, cr_c;
  logic signed [ProdW-1:0]  rv_p, gu_p, gv_p, bu_p;
  logic [PixW-1:0]          luma_in [4];

  assign cb_c = $signed({1'b0, chroma_b_i}) - $signed({1'b0, ChromaOffset});
  assign cr_c = $signed({1'b0, chroma_r_i}) - $signed({1'b0, ChromaOffset});
  assign rv_p = cr_c * CoefRv;
  assign gu_p = cb_c * CoefGu;
  assign gv_p = cr_c * CoefGv;
  assign bu_p = cb_c * CoefBu;

  assign luma_in[0] = luma_tl_i;
  assign luma_in[1] = luma_tr_i;
  assign luma_in[2] = luma_bl_i;
  assign luma_in[3] = luma_br_i;

  logic                    v1_q;
  logic signed [TermW-1:0] rt1_q, gu1_q, gv1_q, bt1_q;
  logic [PixW-1:0]         luma1_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    rt1_q   <= rv_p[TermW-1:0];
    gu1_q   <= gu_p[TermW-1:0];
    gv1_q   <= gv_p[TermW-1:0];
    bt1_q   <= bu_p[TermW-1:0];
    luma1_q <= luma_in;
  end

  // Stage 2: combine the two green terms.
  logic                    v2_q;
  logic signed [TermW-1:0] rt2_q, gt2_q, bt2_q;
  logic [PixW-1:0]         luma2_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rt2_q   <= rt1_q;
    gt2_q   <= gu1_q + gv1_q;
    bt2_q   <= bt1_q;
    luma2_q <= luma1_q;
  end

  // Stage 3: add the scaled luma to each chroma term for all four pixels.
  logic                  v3_q;
  logic signed [SumW-1:0] rs3_q [4];
  logic signed [SumW-1:0] gs3_q [4];
  logic signed [SumW-1:0] bs3_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_sum
    logic signed [SumW-1:0] ys;
    assign ys = $signed({2'b00, luma2_q[k], 16'd0});
    always_ff @(posedge clk_i) begin
      rs3_q[k] <= ys + SumW'(rt2_q);
      gs3_q[k] <= ys + SumW'(gt2_q);
      bs3_q[k] <= ys + SumW'(bt2_q);
    end
  end

  // Stage 4: clamp, pack and register the result.
  logic            done_q;
  logic [OutW-1:0] pix_d [4];
  logic [OutW-1:0] pix_q [4];

  for (genvar k = 0; k < 4; k++) begin : g_pack
    assign pix_d[k] = pack_pixel(fmt_q, sat_chan(rs3_q[k]), sat_chan(gs3_q[k]),
                                 sat_chan(bs3_q[k]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q <= pix_d;
  end

  assign done_o     = done_q;
  assign pixel_tl_o = pix_q[0];
  assign pixel_tr_o = pix_q[1];
  assign pixel_bl_o = pix_q[2];
  assign pixel_br_o = pix_q[3];

endmodule
